// ===== rtl/phase_current_reconstruct_park_assert.svh =====
// Assertion macros for the phase current rebuild block.
// Used by the top level; relies on a clk and rst in the including scope.
`ifndef PHASE_CURRENT_RECONSTRUCT_PARK_ASSERT_SVH
`define PHASE_CURRENT_RECONSTRUCT_PARK_ASSERT_SVH
`ifndef SYNTHESIS
// checked outside reset
`define PCRP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define PCRP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCRP_ASSERT(name, prop, msg)
`define PCRP_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ===== rtl/pcrp_pkg.sv =====
// Shared widths, sector codes, sideband type and rounding helpers.
// No dependencies; imported by every pcrp module.
`timescale 1ns / 1ps
package pcrp_pkg;

  localparam int CW      = 16;          // current width
  localparam int TW      = 16;          // sin/cos width, Q1.(TW-1)
  localparam int ONW     = 16;          // on-time width
  localparam int DENW    = ONW + 1;     // on-time sum
  localparam int DW      = DENW + 1;    // divisor = 2 * sum
  localparam int QW      = CW + 1;      // quotient, up to 2^(CW-1)
  localparam int NW      = QW + ONW;    // dividend 2*mag*num + den
  localparam int KW      = 16;
  localparam int INV_SQRT3 = 18919;     // 1/sqrt(3) in Q0.15
  localparam int KFRAC   = 15;
  localparam int PRODW   = CW + 1 + KW + 1;
  localparam int BW      = PRODW - KFRAC;
  localparam int PW      = BW + TW;
  localparam int SUMW    = 40;

  localparam logic [2:0] SEC_U  = 3'd0;
  localparam logic [2:0] SEC_UV = 3'd1;
  localparam logic [2:0] SEC_V  = 3'd2;
  localparam logic [2:0] SEC_VW = 3'd3;
  localparam logic [2:0] SEC_W  = 3'd4;
  localparam logic [2:0] SEC_WU = 3'd5;

  typedef struct packed {
    logic signed [CW-1:0] u;
    logic signed [CW-1:0] v;
    logic signed [CW-1:0] w;
    logic [2:0]           sec;
    logic                 two;
    logic                 den_zero;
    logic                 neg;
    logic signed [TW-1:0] s;
    logic signed [TW-1:0] c;
  } side_t;

  // saturate to a signed current
  function automatic logic signed [CW-1:0] sat_cur(input logic signed [SUMW-1:0] x);
    logic signed [SUMW-1:0] hi;
    logic signed [SUMW-1:0] lo;
    hi = SUMW'((SUMW'(1) <<< (CW-1)) - 1);
    lo = -hi - SUMW'(1);
    if (x > hi) return hi[CW-1:0];
    else if (x < lo) return lo[CW-1:0];
    else return x[CW-1:0];
  endfunction

  // negate with saturation
  function automatic logic signed [CW-1:0] neg_sat(input logic signed [CW-1:0] x);
    return sat_cur(-SUMW'(x));
  endfunction

  // x / 2^n rounded to nearest, ties away from zero
  function automatic logic signed [SUMW-1:0] round_sh(input logic signed [SUMW-1:0] x,
                                                      input int n);
    logic signed [SUMW-1:0] half;
    half = SUMW'(1) <<< (n - 1);
    if (x < 0) return (x + half - SUMW'(1)) >>> n;
    else return (x + half) >>> n;
  endfunction

endpackage

// ===== rtl/pcrp_front.sv =====
// Front stages: negation, sector rules, on-time split setup and products.
// Depends on pcrp_pkg.
`timescale 1ns / 1ps
module pcrp_front import pcrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ce,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] raw_u,
  input  logic signed [CW-1:0] raw_v,
  input  logic signed [CW-1:0] raw_w,
  input  logic [2:0]           pwm_sector,
  input  logic [ONW-1:0]       on_u,
  input  logic [ONW-1:0]       on_v,
  input  logic [ONW-1:0]       on_w,
  input  logic signed [TW-1:0] sin_angle,
  input  logic signed [TW-1:0] cos_angle,
  output logic                 out_valid,
  output logic [NW-1:0]        n_a,
  output logic [NW-1:0]        n_b,
  output logic [DW-1:0]        d,
  output side_t                side
);

  // stage A: negated readings
  logic                 a_valid;
  logic signed [CW-1:0] a_u, a_v, a_w;
  logic [2:0]           a_sec;
  logic [ONW-1:0]       a_tu, a_tv, a_tw;
  logic signed [TW-1:0] a_s, a_c;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (ce) a_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a_u   <= neg_sat(raw_u);
      a_v   <= neg_sat(raw_v);
      a_w   <= neg_sat(raw_w);
      a_sec <= pwm_sector;
      a_tu  <= on_u;
      a_tv  <= on_v;
      a_tw  <= on_w;
      a_s   <= sin_angle;
      a_c   <= cos_angle;
    end
  end

  // stage B: sector rule, returning current magnitude, split operands
  side_t          b_side, b_side_next;
  logic           b_valid;
  logic [QW-1:0]  b_mag, b_mag_next;
  logic [ONW-1:0] b_num_a, b_num_a_next, b_num_b, b_num_b_next;
  logic [DENW-1:0] b_den, b_den_next;
  logic signed [CW-1:0] ret_src;

  always_comb begin
    b_side_next          = '0;
    b_side_next.u        = a_u;
    b_side_next.v        = a_v;
    b_side_next.w        = a_w;
    b_side_next.sec      = a_sec;
    b_side_next.s        = a_s;
    b_side_next.c        = a_c;
    b_num_a_next         = '0;
    b_num_b_next         = '0;
    b_den_next           = '0;
    ret_src              = '0;
    unique case (a_sec)
      SEC_U: b_side_next.u = sat_cur(-(SUMW'(a_v) + SUMW'(a_w)));
      SEC_V: b_side_next.v = sat_cur(-(SUMW'(a_u) + SUMW'(a_w)));
      SEC_W: b_side_next.w = sat_cur(-(SUMW'(a_u) + SUMW'(a_v)));
      SEC_UV: begin
        b_side_next.two = 1'b1;
        ret_src         = a_w;
        b_num_a_next    = a_tu;
        b_num_b_next    = a_tv;
      end
      SEC_VW: begin
        b_side_next.two = 1'b1;
        ret_src         = a_u;
        b_num_a_next    = a_tv;
        b_num_b_next    = a_tw;
      end
      SEC_WU: begin
        b_side_next.two = 1'b1;
        ret_src         = a_v;
        b_num_a_next    = a_tu;
        b_num_b_next    = a_tw;
      end
      default: ;
    endcase
    b_den_next           = DENW'(b_num_a_next) + DENW'(b_num_b_next);
    b_side_next.den_zero = (b_den_next == '0);
    // returning current is minus the source: negative when source is positive
    b_side_next.neg      = !ret_src[CW-1] && (ret_src != '0);
    b_mag_next           = ret_src[CW-1] ? QW'(-SUMW'(ret_src)) : QW'(ret_src);
  end

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (ce) b_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      b_side  <= b_side_next;
      b_mag   <= b_mag_next;
      b_num_a <= b_num_a_next;
      b_num_b <= b_num_b_next;
      b_den   <= b_den_next;
    end
  end

  // stage C: dividends 2*mag*num + den, divisor 2*den
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ce) out_valid <= b_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      n_a  <= ((NW'(b_mag) * NW'(b_num_a)) << 1) + NW'(b_den);
      n_b  <= ((NW'(b_mag) * NW'(b_num_b)) << 1) + NW'(b_den);
      d    <= {b_den, 1'b0};
      side <= b_side;
    end
  end

endmodule

// ===== rtl/pcrp_div.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on pcrp_pkg; carries the item sideband alongside.
`timescale 1ns / 1ps
module pcrp_div import pcrp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          ce,
  input  logic          in_valid,
  input  logic [NW-1:0] n_a,
  input  logic [NW-1:0] n_b,
  input  logic [DW-1:0] d,
  input  side_t         side_in,
  output logic          out_valid,
  output logic [QW-1:0] q_a,
  output logic [QW-1:0] q_b,
  output side_t         side_out
);

  logic [DW-1:0] rem_a [QW];
  logic [DW-1:0] rem_b [QW];
  logic [QW-1:0] low_a [QW];
  logic [QW-1:0] low_b [QW];
  logic [QW-1:0] quo_a [QW];
  logic [QW-1:0] quo_b [QW];
  logic [DW-1:0] dv    [QW];
  side_t         sd    [QW];
  logic          vld   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [DW-1:0] ra_i, rb_i, d_i;
    logic [QW-1:0] la_i, lb_i, qa_i, qb_i;
    side_t         sd_i;
    logic          v_i;
    logic [DW:0]   sh_a, sh_b;
    logic          ge_a, ge_b;

    if (k == 0) begin : g_head
      // high dividend bits are already below the divisor
      assign ra_i = DW'(n_a[NW-1:QW]);
      assign rb_i = DW'(n_b[NW-1:QW]);
      assign la_i = n_a[QW-1:0];
      assign lb_i = n_b[QW-1:0];
      assign qa_i = '0;
      assign qb_i = '0;
      assign d_i  = d;
      assign sd_i = side_in;
      assign v_i  = in_valid;
    end else begin : g_body
      assign ra_i = rem_a[k-1];
      assign rb_i = rem_b[k-1];
      assign la_i = low_a[k-1];
      assign lb_i = low_b[k-1];
      assign qa_i = quo_a[k-1];
      assign qb_i = quo_b[k-1];
      assign d_i  = dv[k-1];
      assign sd_i = sd[k-1];
      assign v_i  = vld[k-1];
    end

    // shift in next dividend bit, trial subtract
    assign sh_a = {ra_i, la_i[QW-1]};
    assign sh_b = {rb_i, lb_i[QW-1]};
    assign ge_a = sh_a >= {1'b0, d_i};
    assign ge_b = sh_b >= {1'b0, d_i};

    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else if (ce) vld[k] <= v_i;
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_a[k] <= ge_a ? DW'(sh_a - {1'b0, d_i}) : DW'(sh_a);
        rem_b[k] <= ge_b ? DW'(sh_b - {1'b0, d_i}) : DW'(sh_b);
        low_a[k] <= {la_i[QW-2:0], 1'b0};
        low_b[k] <= {lb_i[QW-2:0], 1'b0};
        quo_a[k] <= {qa_i[QW-2:0], ge_a};
        quo_b[k] <= {qb_i[QW-2:0], ge_b};
        dv[k]    <= d_i;
        sd[k]    <= sd_i;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign q_a       = quo_a[QW-1];
  assign q_b       = quo_b[QW-1];
  assign side_out  = sd[QW-1];

endmodule

// ===== rtl/pcrp_park.sv =====
// Back stages: split currents, Clarke beta, Park rotation, saturation.
// Depends on pcrp_pkg.
`timescale 1ns / 1ps
module pcrp_park import pcrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ce,
  input  logic                 in_valid,
  input  logic [QW-1:0]        q_a,
  input  logic [QW-1:0]        q_b,
  input  side_t                side,
  output logic                 out_valid,
  output logic signed [CW-1:0] phase_u,
  output logic signed [CW-1:0] phase_v,
  output logic signed [CW-1:0] phase_w,
  output logic signed [CW-1:0] current_d,
  output logic signed [CW-1:0] current_q
);

  // stage E: signed, saturated split currents placed by sector
  logic                 e_valid;
  logic signed [CW-1:0] e_u, e_v, e_w, e_u_next, e_v_next, e_w_next;
  logic signed [TW-1:0] e_s, e_c;
  logic signed [CW-1:0] fa, fb;

  always_comb begin
    fa = side.neg ? sat_cur(-SUMW'(q_a)) : sat_cur(SUMW'(q_a));
    fb = side.neg ? sat_cur(-SUMW'(q_b)) : sat_cur(SUMW'(q_b));
    if (side.den_zero) begin
      fa = '0;
      fb = '0;
    end
    e_u_next = side.u;
    e_v_next = side.v;
    e_w_next = side.w;
    if (side.two) begin
      unique case (side.sec)
        SEC_UV: begin
          e_u_next = fa;
          e_v_next = fb;
        end
        SEC_VW: begin
          e_v_next = fa;
          e_w_next = fb;
        end
        SEC_WU: begin
          e_u_next = fa;
          e_w_next = fb;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) e_valid <= 1'b0;
    else if (ce) e_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      e_u <= e_u_next;
      e_v <= e_v_next;
      e_w <= e_w_next;
      e_s <= side.s;
      e_c <= side.c;
    end
  end

  // stage F: (v - w) * 1/sqrt(3)
  logic                    f_valid;
  logic signed [PRODW-1:0] f_prod;
  logic signed [CW-1:0]    f_u, f_v, f_w;
  logic signed [TW-1:0]    f_s, f_c;
  logic signed [CW:0]      diff;
  logic signed [KW:0]      kc;

  assign diff = (CW+1)'(e_v) - (CW+1)'(e_w);
  assign kc   = (KW+1)'(INV_SQRT3);

  always_ff @(posedge clk) begin
    if (rst) f_valid <= 1'b0;
    else if (ce) f_valid <= e_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f_prod <= PRODW'(diff) * PRODW'(kc);
      f_u    <= e_u;
      f_v    <= e_v;
      f_w    <= e_w;
      f_s    <= e_s;
      f_c    <= e_c;
    end
  end

  // stage G: round beta to a current LSB
  logic                 g_valid;
  logic signed [BW-1:0] g_beta;
  logic signed [CW-1:0] g_u, g_v, g_w;
  logic signed [TW-1:0] g_s, g_c;
  logic signed [SUMW-1:0] beta_full;

  assign beta_full = round_sh(SUMW'(f_prod), KFRAC);

  always_ff @(posedge clk) begin
    if (rst) g_valid <= 1'b0;
    else if (ce) g_valid <= f_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      g_beta <= beta_full[BW-1:0];
      g_u    <= f_u;
      g_v    <= f_v;
      g_w    <= f_w;
      g_s    <= f_s;
      g_c    <= f_c;
    end
  end

  // stage H: four Park products
  logic                 h_valid;
  logic signed [PW-1:0] h_bs, h_uc, h_bc, h_us;
  logic signed [CW-1:0] h_u, h_v, h_w;

  always_ff @(posedge clk) begin
    if (rst) h_valid <= 1'b0;
    else if (ce) h_valid <= g_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      h_bs <= PW'(g_beta) * PW'(g_s);
      h_uc <= PW'(g_u) * PW'(g_c);
      h_bc <= PW'(g_beta) * PW'(g_c);
      h_us <= PW'(g_u) * PW'(g_s);
      h_u  <= g_u;
      h_v  <= g_v;
      h_w  <= g_w;
    end
  end

  // stage I: sum, round once, saturate; this is the output register
  logic signed [SUMW-1:0] d_full, q_full;

  assign d_full = round_sh(SUMW'(h_bs) + SUMW'(h_uc), TW - 1);
  assign q_full = round_sh(SUMW'(h_bc) - SUMW'(h_us), TW - 1);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ce) out_valid <= h_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      phase_u   <= h_u;
      phase_v   <= h_v;
      phase_w   <= h_w;
      current_d <= sat_cur(d_full);
      current_q <= sat_cur(q_full);
    end
  end

endmodule

// ===== rtl/phase_current_reconstruct_park.sv =====
// channel   dir  beat contents
// s_axis    in   raw_u, raw_v, raw_w, pwm_sector, on_u, on_v, on_w, sin_angle, cos_angle
// m_axis    out  phase_u, phase_v, phase_w, current_d, current_q
//
// One beat per cycle sustained while the output is not stalled; 3 front, 17 divider and 5 back stages.
// The on-time split runs through a 17-stage one-bit-per-stage divider.
// Reset (rst, synchronous) clears only the stage valid bits.
// All stages advance together when the output register is empty or taken;
// a stalled output holds every stage and s_tready drops.
`timescale 1ns / 1ps
`include "phase_current_reconstruct_park_assert.svh"
module phase_current_reconstruct_park import pcrp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // raw_u[15:0] raw_v[31:16] raw_w[47:32] pwm_sector[50:48] on_u[66:51]
  // on_v[82:67] on_w[98:83] sin_angle[114:99] cos_angle[130:115], zero pad
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // phase_u[15:0] phase_v[31:16] phase_w[47:32] current_d[63:48] current_q[79:64]
  output logic [79:0]  m_tdata
);

  logic                 ce;
  logic                 fr_valid, dv_valid;
  logic [NW-1:0]        fr_n_a, fr_n_b;
  logic [DW-1:0]        fr_d;
  side_t                fr_side, dv_side;
  logic [QW-1:0]        dv_q_a, dv_q_b;
  logic signed [CW-1:0] pu, pv, pw, cd, cq;

  // whole pipeline moves when the output slot frees up
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  pcrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_tvalid),
    .raw_u     (s_tdata[15:0]),
    .raw_v     (s_tdata[31:16]),
    .raw_w     (s_tdata[47:32]),
    .pwm_sector(s_tdata[50:48]),
    .on_u      (s_tdata[66:51]),
    .on_v      (s_tdata[82:67]),
    .on_w      (s_tdata[98:83]),
    .sin_angle (s_tdata[114:99]),
    .cos_angle (s_tdata[130:115]),
    .out_valid (fr_valid),
    .n_a       (fr_n_a),
    .n_b       (fr_n_b),
    .d         (fr_d),
    .side      (fr_side)
  );

  pcrp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (fr_valid),
    .n_a      (fr_n_a),
    .n_b      (fr_n_b),
    .d        (fr_d),
    .side_in  (fr_side),
    .out_valid(dv_valid),
    .q_a      (dv_q_a),
    .q_b      (dv_q_b),
    .side_out (dv_side)
  );

  pcrp_park u_park (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (dv_valid),
    .q_a      (dv_q_a),
    .q_b      (dv_q_b),
    .side     (dv_side),
    .out_valid(m_tvalid),
    .phase_u  (pu),
    .phase_v  (pv),
    .phase_w  (pw),
    .current_d(cd),
    .current_q(cq)
  );

  assign m_tdata = {cq, cd, pw, pv, pu};

  // checks
  `PCRP_ASSERT_ALWAYS(a_rst_empty, $past(rst) |-> !m_tvalid, "output valid right after reset")
  `PCRP_ASSERT(a_stall_back, m_tvalid && !m_tready |-> !s_tready, "input taken during stall")
  `PCRP_ASSERT(a_ready_cause, !s_tready |-> m_tvalid, "input blocked with empty output")

endmodule

// ===== bench/park_checker.sv =====
// Checker for the phase current rebuild block: predicts each output beat
// from the accepted input beat and compares field by field. Uses pcrp_pkg.
`timescale 1ns / 1ps
module park_checker import pcrp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [135:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [79:0]  m_tdata,
  output int           errors,
  output int           pending
);

  logic [79:0] expected_q[$];

  assign pending = expected_q.size();

  function automatic longint clamp16(input longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  // divide by 2^n, nearest, ties away from zero
  function automatic longint rnd_shift(input longint x, input int n);
    longint m;
    m = (x < 0) ? -x : x;
    m = (m + (longint'(1) << (n - 1))) >>> n;
    return (x < 0) ? -m : m;
  endfunction

  // share of the returning current by on-time ratio
  function automatic longint split(input longint cur, input longint num, input longint den);
    longint m;
    m = (cur < 0) ? -cur : cur;
    m = (2 * m * num + den) / (2 * den);
    return (cur < 0) ? -m : m;
  endfunction

  function automatic logic [79:0] rebuild_dq(input logic [135:0] b);
    longint u, v, w, tu, tv, tw, s, c, den, beta, d, q;
    logic [2:0] sector;
    u = clamp16(-longint'($signed(b[15:0])));
    v = clamp16(-longint'($signed(b[31:16])));
    w = clamp16(-longint'($signed(b[47:32])));
    sector = b[50:48];
    tu = b[66:51];
    tv = b[82:67];
    tw = b[98:83];
    s = $signed(b[114:99]);
    c = $signed(b[130:115]);
    case (sector)
      SEC_U: u = clamp16(-(v + w));
      SEC_V: v = clamp16(-(u + w));
      SEC_W: w = clamp16(-(u + v));
      SEC_UV: begin
        den = tu + tv;
        if (den == 0) begin u = 0; v = 0; end
        else begin u = clamp16(split(-w, tu, den)); v = clamp16(split(-w, tv, den)); end
      end
      SEC_VW: begin
        den = tv + tw;
        if (den == 0) begin v = 0; w = 0; end
        else begin v = clamp16(split(-u, tv, den)); w = clamp16(split(-u, tw, den)); end
      end
      SEC_WU: begin
        den = tu + tw;
        if (den == 0) begin u = 0; w = 0; end
        else begin u = clamp16(split(-v, tu, den)); w = clamp16(split(-v, tw, den)); end
      end
      default: ;
    endcase
    beta = rnd_shift((v - w) * INV_SQRT3, KFRAC);
    d = clamp16(rnd_shift(beta * s + u * c, TW - 1));
    q = clamp16(rnd_shift(beta * c - u * s, TW - 1));
    return {q[15:0], d[15:0], w[15:0], v[15:0], u[15:0]};
  endfunction

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("%0t: %s got %0d expected %0d", $time, what, $signed(got), $signed(want));
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    logic [79:0] want;
    if (!rst) begin
      if (s_tvalid && s_tready) expected_q.push_back(rebuild_dq(s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: output beat with nothing expected", $time);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (m_tdata[15:0] !== want[15:0]) report("phase_u", m_tdata[15:0], want[15:0]);
          if (m_tdata[31:16] !== want[31:16]) report("phase_v", m_tdata[31:16], want[31:16]);
          if (m_tdata[47:32] !== want[47:32]) report("phase_w", m_tdata[47:32], want[47:32]);
          if (m_tdata[63:48] !== want[63:48])
            report("current_d", m_tdata[63:48], want[63:48]);
          if (m_tdata[79:64] !== want[79:64])
            report("current_q", m_tdata[79:64], want[79:64]);
        end
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the bench: drives sample sets into the rebuild/Park block, stalls
// both sides, and gives the verdict. Needs pcrp_pkg, the block and park_checker.
`timescale 1ns / 1ps
module testbench import pcrp_pkg::*;;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [79:0]  m_tdata;
  int           errors, pending;
  int           send_idle = 0;   // percent
  int           recv_idle = 0;   // percent
  bit           hold_off = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  phase_current_reconstruct_park uut (.*);

  park_checker chk (.*);

  // receiver readiness
  always @(posedge clk) begin
    if (rst || hold_off) m_tready <= 0;
    else m_tready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [15:0] pick16();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_on();
    case ($urandom_range(4))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [135:0] pack(input logic [15:0] ru, rv, rw, input logic [2:0] sec,
                                        input logic [15:0] tu, tv, tw, sn, cs);
    return {5'b0, cs, sn, tw, tv, tu, sec, rw, rv, ru};
  endfunction

  // offer one beat, with random gaps, and hold it until taken
  task automatic send(input logic [135:0] beat);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= beat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random();
    logic [15:0] tu, tv, tw;
    tu = pick_on(); tv = pick_on(); tw = pick_on();
    if ($urandom_range(9) == 0) begin tu = 0; tv = 0; tw = 0; end
    send(pack(pick16(), pick16(), pick16(), 3'($urandom_range(7)), tu, tv, tw,
              pick16(), pick16()));
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [2:0] sec;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: every sector, extremes, zero on-time sums
    for (int k = 0; k < 8; k++) begin
      sec = 3'(k);
      send(pack(16'h8000, 16'h7fff, 16'h8000, sec, 16'hffff, 16'h0001, 16'hffff,
                16'h7fff, 16'h8000));
      send(pack(16'h7fff, 16'h8000, 16'h7fff, sec, 16'h0000, 16'h0000, 16'h0000,
                16'h8000, 16'h7fff));
    end
    send(pack(16'd100, 16'hff00, 16'd7, SEC_UV, 16'd3, 16'd1, 16'd0, 16'h5a82, 16'h5a82));
    send(pack(16'hffff, 16'hffff, 16'hffff, SEC_VW, 16'hffff, 16'hffff, 16'hffff,
              16'hffff, 16'hffff));
    send(pack(16'd0, 16'd0, 16'd0, SEC_WU, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0));
    // sender pauses until every result is in
    drain();
    // long receiver hold-off while the sender keeps offering
    hold_off = 1;
    fork
      begin repeat (120) @(posedge clk); hold_off = 0; end
      for (int k = 0; k < 60; k++) send_random();
    join
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 28 : (phase == 1) ? 63 : 0;
      recv_idle = (phase == 0) ? 63 : (phase == 1) ? 28 : 0;
      for (int k = 0; k < 290; k++) send_random();
    end
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== phase_current_reconstruct_park.f =====
+incdir+rtl
rtl/pcrp_pkg.sv
rtl/pcrp_front.sv
rtl/pcrp_div.sv
rtl/pcrp_park.sv
rtl/phase_current_reconstruct_park.sv
bench/park_checker.sv
bench/testbench.sv
